// File: hw/rtl/rcs_pkg.sv
// rcs_pkg: shared types and constants of the region chunk splitter
// used by rcs_dp, rcs_ctrl and the top level; depends on nothing

package rcs_pkg;

  localparam int MaxSpanDefault = 8;

  // register indexes of the configuration port
  localparam logic [1:0] RegChunkWidth  = 2'd0;
  localparam logic [1:0] RegChunkHeight = 2'd1;
  localparam logic [1:0] RegImageWidth  = 2'd2;
  localparam logic [1:0] RegImageHeight = 2'd3;

  localparam int CfgW   = 21;  // widest register
  localparam int CSizeW = 17;  // chunk size
  localparam int ImgW   = 21;  // image size
  localparam int DivW   = 22;  // dividend and quotient of the edge divisions
  localparam int PosW   = 23;  // pixel positions during the walk
  localparam int InW    = 104; // input word, padded to bytes
  localparam int OutW   = 168; // result word, padded to bytes

  // commands from controller to datapath
  typedef struct packed {
    logic cap;       // capture the input word
    logic div_start; // start the edge divisions
    logic base_load; // load first column/row and their pixel origins
    logic step;      // visit the current chunk and advance
    logic flush;     // move the pending result out as the final one
    logic err_load;  // load the span error result
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic empty;
    logic div_busy;
    logic span_err;
    logic cand_ok;
    logic walk_end;
    logic pend_valid;
    logic out_free;
  } stat_t;

endpackage

// File: hw/rtl/rcs_div.sv
// rcs_div: restoring divider, one quotient bit per cycle
// uses no package; instantiated by rcs_dp

module rcs_div #(
  parameter int DW = 22,
  parameter int VW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);

  localparam int CntW = $clog2(DW + 1);

  logic [VW-1:0]   rem;
  logic [VW-1:0]   dvs;
  logic [DW-1:0]   q;
  logic [CntW-1:0] cnt;
  logic [VW:0]     rem_sh;
  logic [VW:0]     diff;
  logic            fits;

  // shift in next dividend bit and try subtracting
  assign rem_sh = {rem, q[DW-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CntW'(DW);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= cnt != CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      q   <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[VW-1:0] : rem_sh[VW-1:0];
      q   <= {q[DW-2:0], fits};
    end
  end

  assign quotient = q;

endmodule

// File: hw/rtl/rcs_dp.sv
// rcs_dp: datapath of the splitter: config registers, dividers, walk, results
// depends on rcs_pkg and rcs_div

module rcs_dp #(
  parameter int MAX_SPAN = rcs_pkg::MaxSpanDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_addr,
  input  logic [rcs_pkg::CfgW-1:0] cfg_data,
  input  logic [rcs_pkg::InW-1:0]  in_word,
  input  rcs_pkg::cmd_t            cmd,
  output rcs_pkg::stat_t           st,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [rcs_pkg::OutW-1:0] out_word,
  output logic                     out_last,
  output logic                     out_err
);

  localparam int DW = rcs_pkg::DivW;
  localparam int PW = rcs_pkg::PosW;
  localparam int CW = rcs_pkg::CSizeW;
  localparam int IW = rcs_pkg::ImgW;
  localparam int PayW = 162;

  logic [CW-1:0] chunk_width, chunk_height;
  logic [IW-1:0] image_width, image_height;
  logic [CW-1:0] cw, ch;

  logic [19:0] rx, ry;
  logic [20:0] rw, rh;
  logic [15:0] blk;

  logic [DW-1:0] qfc, qfr, qlc, qlr;
  logic          bfc, bfr, blc, blr;

  logic [DW-1:0] col, row;
  logic [PW-1:0] left, top, left0;

  logic [PW-1:0] rx_e, ry_e, rx_end, ry_end;
  logic [PW-1:0] right, bottom, il, it, ir, ib;
  logic [PW-1:0] sx, sy, dx, dy, cpw, cph;
  logic [PW-1:0] l_sum, t_sum;
  logic [PayW-1:0] cand;

  logic            pend_valid;
  logic [PayW-1:0] pend;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_width  <= CW'(256);
      chunk_height <= CW'(256);
      image_width  <= IW'(1048576);
      image_height <= IW'(1048576);
    end else if (cfg_we) begin
      case (cfg_addr)
        rcs_pkg::RegChunkWidth:  chunk_width  <= cfg_data[CW-1:0];
        rcs_pkg::RegChunkHeight: chunk_height <= cfg_data[CW-1:0];
        rcs_pkg::RegImageWidth:  image_width  <= cfg_data;
        rcs_pkg::RegImageHeight: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // chunk size: zero counts as one, above 65536 clamps
  always_comb begin
    cw = chunk_width;
    if (chunk_width == '0) cw = CW'(1);
    else if (chunk_width > CW'(65536)) cw = CW'(65536);
    ch = chunk_height;
    if (chunk_height == '0) ch = CW'(1);
    else if (chunk_height > CW'(65536)) ch = CW'(65536);
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      rx  <= in_word[19:0];
      ry  <= in_word[39:20];
      rw  <= in_word[60:40];
      rh  <= in_word[81:61];
      blk <= in_word[97:82];
    end
  end

  assign rx_e   = PW'(rx);
  assign ry_e   = PW'(ry);
  assign rx_end = rx_e + PW'(rw);
  assign ry_end = ry_e + PW'(rh);

  // first and last chunk column and row
  rcs_div #(.DW(DW), .VW(CW)) u_div_fc (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(DW'(rx)),
    .divisor(cw), .busy(bfc), .quotient(qfc));
  rcs_div #(.DW(DW), .VW(CW)) u_div_fr (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(DW'(ry)),
    .divisor(ch), .busy(bfr), .quotient(qfr));
  rcs_div #(.DW(DW), .VW(CW)) u_div_lc (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend(DW'(rx_end - PW'(1))), .divisor(cw), .busy(blc), .quotient(qlc));
  rcs_div #(.DW(DW), .VW(CW)) u_div_lr (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend(DW'(ry_end - PW'(1))), .divisor(ch), .busy(blr), .quotient(qlr));

  // walk position; pixel origins are accumulated, seeded by a multiply per axis
  always_ff @(posedge clk) begin
    if (cmd.base_load) begin
      col   <= qfc;
      row   <= qfr;
      left  <= PW'(qfc * cw);
      left0 <= PW'(qfc * cw);
      top   <= PW'(qfr * ch);
    end else if (cmd.step) begin
      if (col == qlc) begin
        col <= qfc;
        left <= left0;
        row <= row + 1'b1;
        top <= t_sum;
      end else begin
        col  <= col + 1'b1;
        left <= l_sum;
      end
    end
  end

  // overlap of the current chunk with the region
  always_comb begin
    l_sum  = left + PW'(cw);
    t_sum  = top + PW'(ch);
    right  = (l_sum < PW'(image_width)) ? l_sum : PW'(image_width);
    bottom = (t_sum < PW'(image_height)) ? t_sum : PW'(image_height);
    il     = (left > rx_e) ? left : rx_e;
    it     = (top > ry_e) ? top : ry_e;
    ir     = (right < rx_end) ? right : rx_end;
    ib     = (bottom < ry_end) ? bottom : ry_end;
    sx     = il - left;
    sy     = it - top;
    dx     = il - rx_e;
    dy     = it - ry_e;
    cpw    = ir - il;
    cph    = ib - it;
    cand   = {cph[16:0], cpw[16:0], dy[19:0], dx[19:0], sy[15:0], sx[15:0],
              blk, row[19:0], col[19:0]};
  end

  // pending result and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.step && st.cand_ok) pend_valid <= 1'b1;
      else if (cmd.flush) pend_valid <= 1'b0;
      if ((cmd.step && st.cand_ok && pend_valid) || cmd.flush || cmd.err_load)
        out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && st.cand_ok) begin
      pend <= cand;
      if (pend_valid) begin
        out_word <= rcs_pkg::OutW'(pend);
        out_last <= 1'b0;
        out_err  <= 1'b0;
      end
    end
    if (cmd.flush) begin
      out_word <= rcs_pkg::OutW'(pend);
      out_last <= 1'b1;
      out_err  <= 1'b0;
    end
    if (cmd.err_load) begin
      out_word <= '0;
      out_last <= 1'b1;
      out_err  <= 1'b1;
    end
  end

  // status
  always_comb begin
    st.empty      = (rw == '0) || (rh == '0);
    st.div_busy   = bfc | bfr | blc | blr;
    st.span_err   = ((qlc - qfc) >= DW'(MAX_SPAN)) || ((qlr - qfr) >= DW'(MAX_SPAN));
    st.cand_ok    = (il < ir) && (it < ib);
    st.walk_end   = (col == qlc) && (row == qlr);
    st.pend_valid = pend_valid;
    st.out_free   = !out_valid || out_ready;
  end

endmodule

// File: hw/rtl/rcs_ctrl.sv
// rcs_ctrl: state machine sequencing capture, division, walk, flush and span error
// depends on rcs_pkg

module rcs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rcs_pkg::stat_t st,
  output rcs_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK   = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_BASE  = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;
  localparam logic [2:0] S_ERR   = 3'd6;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (st.empty) state_next = S_IDLE;
        else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (!st.div_busy) state_next = st.span_err ? S_ERR : S_BASE;
      end
      S_BASE: begin
        cmd.base_load = 1'b1;
        state_next    = S_WALK;
      end
      S_WALK: begin
        // hold while a second result has nowhere to go
        if (!(st.cand_ok && st.pend_valid && !st.out_free)) begin
          cmd.step = 1'b1;
          if (st.walk_end) state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!st.pend_valid) state_next = S_IDLE;
        else if (st.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ERR: begin
        if (st.out_free) begin
          cmd.err_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_flush_has_pend: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |-> st.pend_valid && st.out_free)
    else $error("flush without a pending result or a free output");
  a_step_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.step && st.cand_ok && st.pend_valid |-> st.out_free)
    else $error("result pushed into a full output register");
  a_err_free: assert property (@(posedge clk) disable iff (rst)
    cmd.err_load |-> st.out_free)
    else $error("span error loaded into a full output register");
  a_walk_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.base_load |-> !st.div_busy && !st.span_err)
    else $error("walk started before divisions ended");

endmodule

// File: hw/rtl/region_chunk_splitter_unit.sv
// region_chunk_splitter_unit: top level of the region chunk splitter
// depends on rcs_pkg, rcs_ctrl, rcs_dp and rcs_div
//
// Takes one region word, divides its edges by the chunk sizes with four
// bit-serial dividers running side by side, then walks the covered chunks
// at one chunk per cycle while the output keeps pace, emitting one result
// word for each chunk that overlaps the region, tlast on the final one. An
// item visits up to MAX_SPAN squared chunks; a region wider than MAX_SPAN
// chunks on either axis gives a single word with tuser set and all data
// zero. Results wait in output and pending registers, so a stalled sink
// only slows the walk once a third result is ready. Configuration writes
// take effect at once and are meant to be made while the unit is idle.

module region_chunk_splitter_unit #(
  parameter int MAX_SPAN = rcs_pkg::MaxSpanDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_addr,
  input  logic [rcs_pkg::CfgW-1:0] cfg_data,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // region_x[19:0], region_y[39:20], region_w[60:40], region_h[81:61],
  // channel_block[97:82], zero pad
  input  logic [rcs_pkg::InW-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // chunk_col[19:0], chunk_row[39:20], block_out[55:40], src_x[71:56],
  // src_y[87:72], dst_x[107:88], dst_y[127:108], copy_w[144:128],
  // copy_h[161:145], zero pad
  output logic [rcs_pkg::OutW-1:0] m_tdata,
  output logic                     m_tlast,
  // span_error
  output logic                     m_tuser
);

  rcs_pkg::cmd_t  cmd;
  rcs_pkg::stat_t st;

  rcs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .st(st), .cmd(cmd));

  rcs_dp #(.MAX_SPAN(MAX_SPAN)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_data(cfg_data), .in_word(s_tdata), .cmd(cmd), .st(st),
    .out_ready(m_tready), .out_valid(m_tvalid), .out_word(m_tdata),
    .out_last(m_tlast), .out_err(m_tuser));

endmodule
